// ===== rtl/wwr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwr_pkg: shared types and constants of the waveform window RMS unit
// Payload structs of both channels, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package wwr_pkg;

  localparam int RMS_W     = 20;
  localparam int ADDR_W    = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  localparam logic [31:0] BOARD_ENABLE_RST  = 32'hFFFF_FFFF;
  localparam logic [10:0] WINDOW_LENGTH_RST = 11'd994;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_of_waveform;
    logic [4:0]         board;
    logic [4:0]         channel;
    logic               trigger_offbeam;
    logic               trigger_random;
  } in_item_t;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic [ADDR_W-1:0] address;
    logic              to_offbeam;
    logic              to_random;
  } out_item_t;

  // channel address and trigger flags held for one window
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              to_offbeam;
    logic              to_random;
  } wave_tag_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL_A,
    CS_MUL_B,
    CS_CMP,
    CS_MUL_D,
    CS_DIV,
    CS_SQRT,
    CS_DONE
  } calc_state_t;

endpackage
`default_nettype wire

// ===== rtl/waveform_window_rms_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_window_rms_unit: windowed standard deviation of ADC waveforms
// Accumulates samples and squares over a window per channel waveform and
// returns sqrt((N*sum2-sum^2)/(N*(N-1))) with fraction bits, plus address.
// ----------------------------------------------------------------------------
//  channel   ports                         moves
//  in        in_valid/in_ready/in_data     one ADC sample with start marks
//  out       out_valid/out_ready/out_data  rms, channel address, trigger flags
//  cfg       cfg_valid/cfg_ready/cfg_index register write (always ready)
//            cfg_data
//
// A sample is taken every cycle while a window is filling. The last sample
// of a window starts the result sequencer, which keeps in_ready low while
// it steps through two products, compare, a third product, division and
// square root on the shared adder (only up to compare for zero variance).
// Reset is synchronous and needs no clearing pass. A waiting result sits in
// the output register, so a stalled out_ready holds off in_ready only once
// the next result is finished too.
// ----------------------------------------------------------------------------
module waveform_window_rms_unit import wwr_pkg::*; #(
  parameter int NUM_BOARDS         = 32,
  parameter int CHANNELS_PER_BOARD = 32,
  parameter int MAX_WINDOW         = 1024,
  parameter int RMS_FRAC_BITS      = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int CLOG_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = 17 + CLOG_W;
  localparam int SQ_W   = 31 + CLOG_W;

  logic [31:0]         board_enable_r, board_enable_nxt;
  logic [10:0]         window_length_r, window_length_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                in_accept;
  logic                launch;
  logic [CNT_W-1:0]    acc_n;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]     acc_sq;
  wave_tag_t           acc_tag;
  logic                calc_idle;
  logic                res_valid;
  logic                res_take;
  out_item_t           res;

  assign in_ready  = calc_idle;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wwr_accum #(
    .NUM_BOARDS         (NUM_BOARDS),
    .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
    .MAX_WINDOW         (MAX_WINDOW),
    .CNT_W              (CNT_W),
    .SUM_W              (SUM_W),
    .SQ_W               (SQ_W)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept_i        (in_accept),
    .item_i          (in_data),
    .board_enable_i  (board_enable_r),
    .window_length_i (window_length_r),
    .launch_o        (launch),
    .n_o             (acc_n),
    .sum_o           (acc_sum),
    .sq_o            (acc_sq),
    .tag_o           (acc_tag)
  );

  wwr_calc #(
    .CNT_W         (CNT_W),
    .SUM_W         (SUM_W),
    .SQ_W          (SQ_W),
    .RMS_FRAC_BITS (RMS_FRAC_BITS)
  ) u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .launch_i    (launch),
    .n_i         (acc_n),
    .sum_i       (acc_sum),
    .sq_i        (acc_sq),
    .tag_i       (acc_tag),
    .idle_o      (calc_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  always_comb begin
    board_enable_nxt  = board_enable_r;
    window_length_nxt = window_length_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BOARD_ENABLE:  board_enable_nxt  = cfg_data;
        CFG_WINDOW_LENGTH: window_length_nxt = cfg_data[10:0];
        default: begin
          board_enable_nxt  = board_enable_r;
          window_length_nxt = window_length_r;
        end
      endcase
    end

    // move a finished result into the output register when it is free
    res_take      = res_valid && (!out_valid_r || out_ready);
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_enable_r  <= BOARD_ENABLE_RST;
      window_length_r <= WINDOW_LENGTH_RST;
      out_valid_r     <= 1'b0;
    end else begin
      board_enable_r  <= board_enable_nxt;
      window_length_r <= window_length_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_busy_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> !in_ready)
    else $error("input still open after window end");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid_r)
    else $error("taken result not presented");

endmodule
`default_nettype wire

// ===== rtl/wwr_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwr_accum: waveform gating and window accumulation
// Selects waveforms by board and trigger, sums samples and squares over the
// window and launches the result calculation on the last window sample.
// ----------------------------------------------------------------------------
module wwr_accum import wwr_pkg::*; #(
  parameter int NUM_BOARDS         = 32,
  parameter int CHANNELS_PER_BOARD = 32,
  parameter int MAX_WINDOW         = 1024,
  parameter int CNT_W              = 11,
  parameter int SUM_W              = 27,
  parameter int SQ_W               = 41
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept_i,
  input  wire in_item_t                item_i,
  input  wire logic [31:0]             board_enable_i,
  input  wire logic [10:0]             window_length_i,
  output logic                         launch_o,
  output logic [CNT_W-1:0]             n_o,
  output logic signed [SUM_W-1:0]      sum_o,
  output logic [SQ_W-1:0]              sq_o,
  output wave_tag_t                    tag_o
);

  localparam logic [10:0] MAX_LEN   = 11'(MAX_WINDOW);
  localparam logic [5:0]  BOARD_LIM = 6'(NUM_BOARDS);
  localparam logic [10:0] CPB       = 11'(CHANNELS_PER_BOARD);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    collecting_r, collecting_nxt;
  wave_tag_t               tag_r, tag_nxt;

  logic [10:0]             eff_len;
  logic                    enabled;
  logic [10:0]             addr_full;
  logic signed [31:0]      prod;
  logic [CNT_W-1:0]        base_cnt;
  logic signed [SUM_W-1:0] base_sum;
  logic [SQ_W-1:0]         base_sq;
  logic                    coll;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W-1:0] sum_new;
  logic [SQ_W-1:0]         sq_new;
  logic                    fire;
  wave_tag_t               tag_cur;

  always_comb begin
    if (window_length_i < 11'd2) begin
      eff_len = 11'd2;
    end else if (window_length_i > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = window_length_i;
    end

    enabled = ({1'b0, item_i.board} < BOARD_LIM) && board_enable_i[item_i.board] &&
              (item_i.trigger_offbeam || item_i.trigger_random);
    addr_full = 11'(item_i.board) * CPB + 11'(item_i.channel);
    prod      = 32'(item_i.sample) * 32'(item_i.sample);

    // a start sample opens a fresh window and drops any unfinished one
    if (item_i.start_of_waveform) begin
      base_cnt           = '0;
      base_sum           = '0;
      base_sq            = '0;
      coll               = enabled;
      tag_cur.address    = addr_full[ADDR_W-1:0];
      tag_cur.to_offbeam = item_i.trigger_offbeam;
      tag_cur.to_random  = item_i.trigger_random;
    end else begin
      base_cnt = cnt_r;
      base_sum = sum_r;
      base_sq  = sq_r;
      coll     = collecting_r;
      tag_cur  = tag_r;
    end

    cnt_inc = base_cnt + CNT_W'(1);
    sum_new = base_sum + SUM_W'(item_i.sample);
    sq_new  = base_sq + SQ_W'(prod[30:0]);
    fire    = coll && (cnt_inc >= CNT_W'(eff_len));

    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    sq_nxt         = sq_r;
    collecting_nxt = collecting_r;
    tag_nxt        = tag_r;
    if (accept_i) begin
      tag_nxt = tag_cur;
      if (coll) begin
        cnt_nxt        = cnt_inc;
        sum_nxt        = sum_new;
        sq_nxt         = sq_new;
        collecting_nxt = !fire;
      end else begin
        cnt_nxt        = base_cnt;
        sum_nxt        = base_sum;
        sq_nxt         = base_sq;
        collecting_nxt = 1'b0;
      end
    end

    launch_o = accept_i && fire;
    n_o      = cnt_inc;
    sum_o    = sum_new;
    sq_o     = sq_new;
    tag_o    = tag_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
      collecting_r <= 1'b0;
      tag_r        <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      sq_r         <= sq_nxt;
      collecting_r <= collecting_nxt;
      tag_r        <= tag_nxt;
    end
  end

  // an open window never holds a full maximum window of samples
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (cnt_r < CNT_W'(MAX_WINDOW)))
    else $error("window count beyond maximum window");

  a_launch_closes: assert property (@(posedge clk) disable iff (!rst_n)
    launch_o |=> !collecting_r)
    else $error("window still open after launch");

endmodule
`default_nettype wire

// ===== rtl/wwr_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwr_calc: window result sequencer around one shared add/subtract unit
// Shift-add products, compare, restoring division and digit-by-digit
// square root, all stepping through the same adder.
// ----------------------------------------------------------------------------
module wwr_calc import wwr_pkg::*; #(
  parameter int CNT_W         = 11,
  parameter int SUM_W         = 27,
  parameter int SQ_W          = 41,
  parameter int RMS_FRAC_BITS = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    launch_i,
  input  wire logic [CNT_W-1:0]        n_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  input  wire logic [SQ_W-1:0]         sq_i,
  input  wire wave_tag_t               tag_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  wire logic                    res_take_i,
  output out_item_t                    res_o
);

  localparam int A_W    = CNT_W + SQ_W;
  localparam int SC     = 2 * RMS_FRAC_BITS;
  localparam int NUM_W  = ((A_W + SC + 1) / 2) * 2;
  localparam int ROOT_W = NUM_W / 2;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int REM_W  = (ROOT_W + 3 > DEN_W + 1) ? ROOT_W + 3 : DEN_W + 1;
  localparam int ALU_W  = A_W + 1;
  localparam int MPL_W  = SUM_W;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int EXT_W  = (ROOT_W > RMS_W) ? ROOT_W : RMS_W;

  calc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [SUM_W-1:0]   mag_r, mag_nxt;
  logic [A_W-1:0]     acc_r, acc_nxt;
  logic [A_W-1:0]     mcand_r, mcand_nxt;
  logic [MPL_W-1:0]   mplier_r, mplier_nxt;
  logic [A_W-1:0]     a_r, a_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  wave_tag_t          tag_r, tag_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub;
  logic               alu_neg;
  logic               last_step;
  logic [REM_W-1:0]   rem_div_sh, rem_sq_sh;
  logic [SUM_W-1:0]   mag_in;
  logic [EXT_W-1:0]   root_ext;

  // shared adder
  always_comb begin
    rem_div_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
    rem_sq_sh  = {rem_r[REM_W-3:0], num_r[NUM_W-1 -: 2]};
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      CS_MUL_A, CS_MUL_B, CS_MUL_D: begin
        alu_a = ALU_W'(acc_r);
        alu_b = ALU_W'(mcand_r);
      end
      CS_CMP: begin
        alu_a   = ALU_W'(a_r);
        alu_b   = ALU_W'(acc_r);
        alu_sub = 1'b1;
      end
      CS_DIV: begin
        alu_a   = ALU_W'(rem_div_sh);
        alu_b   = ALU_W'(den_r);
        alu_sub = 1'b1;
      end
      CS_SQRT: begin
        alu_a   = ALU_W'(rem_sq_sh);
        alu_b   = ALU_W'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
    alu_neg = alu_res[ALU_W-1];
  end

  always_comb begin
    mag_in    = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    last_step = (step_r == STEP_W'(1));

    state_nxt  = state_r;
    step_nxt   = step_r;
    n_nxt      = n_r;
    mag_nxt    = mag_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    a_nxt      = a_r;
    den_nxt    = den_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    tag_nxt    = tag_r;

    case (state_r)
      CS_IDLE: begin
        if (launch_i) begin
          n_nxt      = n_i;
          mag_nxt    = mag_in;
          tag_nxt    = tag_i;
          acc_nxt    = '0;
          mcand_nxt  = A_W'(sq_i);
          mplier_nxt = MPL_W'(n_i);
          step_nxt   = STEP_W'(CNT_W);
          state_nxt  = CS_MUL_A;
        end
      end
      CS_MUL_A, CS_MUL_B, CS_MUL_D: begin
        if (mplier_r[0]) begin
          acc_nxt = alu_res[A_W-1:0];
        end
        mcand_nxt  = {mcand_r[A_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MPL_W-1:1]};
        step_nxt   = step_r - STEP_W'(1);
        if (last_step) begin
          if (state_r == CS_MUL_A) begin
            a_nxt      = acc_nxt;
            acc_nxt    = '0;
            mcand_nxt  = A_W'(mag_r);
            mplier_nxt = mag_r;
            step_nxt   = STEP_W'(SUM_W);
            state_nxt  = CS_MUL_B;
          end else if (state_r == CS_MUL_B) begin
            state_nxt = CS_CMP;
          end else begin
            den_nxt   = acc_nxt[DEN_W-1:0];
            rem_nxt   = '0;
            step_nxt  = STEP_W'(NUM_W);
            state_nxt = CS_DIV;
          end
        end
      end
      CS_CMP: begin
        // non-positive variance reads as zero
        if (alu_neg || (alu_res[A_W-1:0] == '0)) begin
          root_nxt  = '0;
          state_nxt = CS_DONE;
        end else begin
          num_nxt    = NUM_W'(alu_res[A_W-1:0]) << SC;
          acc_nxt    = '0;
          mcand_nxt  = A_W'(n_r);
          mplier_nxt = MPL_W'(n_r - CNT_W'(1));
          step_nxt   = STEP_W'(CNT_W);
          state_nxt  = CS_MUL_D;
        end
      end
      CS_DIV: begin
        rem_nxt  = alu_neg ? rem_div_sh : alu_res[REM_W-1:0];
        num_nxt  = {num_r[NUM_W-2:0], !alu_neg};
        step_nxt = step_r - STEP_W'(1);
        if (last_step) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_W);
          state_nxt = CS_SQRT;
        end
      end
      CS_SQRT: begin
        if (alu_neg) begin
          rem_nxt  = rem_sq_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end else begin
          rem_nxt  = alu_res[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end
        num_nxt  = {num_r[NUM_W-3:0], 2'b00};
        step_nxt = step_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        if (res_take_i) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    root_ext       = EXT_W'(root_r);
    res_o.rms      = (root_ext > EXT_W'(RMS_MAX)) ? RMS_MAX : root_ext[RMS_W-1:0];
    res_o.address  = tag_r.address;
    res_o.to_offbeam = tag_r.to_offbeam;
    res_o.to_random  = tag_r.to_random;
    res_valid_o    = (state_r == CS_DONE);
    idle_o         = (state_r == CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    mag_r    <= mag_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    a_r      <= a_nxt;
    den_r    <= den_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    tag_r    <= tag_nxt;
  end

  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    launch_i |-> (state_r == CS_IDLE))
    else $error("launch while calculation busy");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_DONE && !res_take_i) |=> (state_r == CS_DONE && $stable(root_r)))
    else $error("result lost before it was taken");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the waveform window RMS unit
// Streams channel waveforms, stray samples and rejected waveforms through the
// block under several board masks and window lengths. Every accepted sample
// runs through a scoreboard that predicts each RMS result, which is then
// compared field by field with what comes out.
// ----------------------------------------------------------------------------
module tb_top;
  import wwr_pkg::*;

  localparam int SETTLE      = 200;   // longer than a full sequencer run
  localparam int IDLE_PCT    = 11;
  localparam int RANDOM_ITEMS = 200;
  localparam int IN_W        = $bits(in_item_t);

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_RAIL, SPREAD_FLAT} spread_t;

  class std_dev_scoreboard;
    localparam int NUM_BOARDS   = 32;
    localparam int CH_PER_BOARD = 32;
    localparam int MAX_WIN      = 1024;
    localparam int FRAC_BITS    = 4;

    logic [31:0]       board_mask;
    logic [10:0]       win_reg;
    int unsigned       count;
    longint            sum;
    longint unsigned   sum_sq;
    bit                active;
    logic [ADDR_W-1:0] held_addr;
    logic              held_ob;
    logic              held_rn;
    out_item_t         pending_results[$];
    int                errors;

    function new();
      board_mask = BOARD_ENABLE_RST;
      win_reg    = WINDOW_LENGTH_RST;
      count      = 0;
      sum        = 0;
      sum_sq     = 0;
      active     = 1'b0;
      held_addr  = '0;
      held_ob    = 1'b0;
      held_rn    = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_BOARD_ENABLE) board_mask = data;
      else if (idx == CFG_WINDOW_LENGTH) win_reg = data[10:0];
    endfunction

    function int unsigned eff_len();
      if (win_reg < 2) return 2;
      if (win_reg > MAX_WIN) return MAX_WIN;
      return 32'(win_reg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    // floor(sqrt(variance) * 2^FRAC_BITS) from the current sums
    function logic [RMS_W-1:0] window_std_dev();
      longint unsigned n, mag, a, b, num, den, q, r, scaled, root;
      n   = 64'(count);
      mag = (sum < 0) ? -sum : sum;
      a   = n * sum_sq;
      b   = mag * mag;
      if (n < 2 || a <= b) return '0;
      num    = a - b;
      den    = n * (n - 1);
      q      = num / den;
      r      = num % den;
      scaled = (q << (2 * FRAC_BITS)) + ((r << (2 * FRAC_BITS)) / den);
      root   = isqrt(scaled);
      if (root > RMS_MAX) return RMS_MAX;
      return root[RMS_W-1:0];
    endfunction

    function void note_sample(in_item_t it);
      longint    s;
      bit        enabled;
      out_item_t res;
      if (it.start_of_waveform) begin
        enabled   = (it.board < NUM_BOARDS) && board_mask[it.board];
        held_addr = ADDR_W'(it.board * CH_PER_BOARD + it.channel);
        held_ob   = it.trigger_offbeam;
        held_rn   = it.trigger_random;
        count     = 0;
        sum       = 0;
        sum_sq    = 0;
        active    = enabled && (held_ob || held_rn);
      end
      if (!active) return;
      s      = $signed(it.sample);
      sum    += s;
      sum_sq += longint'(s * s);
      count++;
      if (count < eff_len()) return;
      res.rms        = window_std_dev();
      res.address    = held_addr;
      res.to_offbeam = held_ob;
      res.to_random  = held_rn;
      pending_results.push_back(res);
      active = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result rms %0d address %0d", got.rms, got.address));
        return;
      end
      exp = pending_results.pop_front();
      if (got.rms !== exp.rms)
        report($sformatf("rms %0d, expected %0d (address %0d)", got.rms, exp.rms,
                         exp.address));
      if (got.address !== exp.address)
        report($sformatf("address %0d, expected %0d", got.address, exp.address));
      if (got.to_offbeam !== exp.to_offbeam)
        report($sformatf("to_offbeam %0b, expected %0b (address %0d)", got.to_offbeam,
                         exp.to_offbeam, exp.address));
      if (got.to_random !== exp.to_random)
        report($sformatf("to_random %0b, expected %0b (address %0d)", got.to_random,
                         exp.to_random, exp.address));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  bit                   steady    = 1'b0;
  int                   items_sent = 0;
  std_dev_scoreboard    sdev = new();

  waveform_window_rms_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sdev.check_result(out_data);
  end

  task automatic send_sample(in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sdev.note_sample(it);
    items_sent++;
  endtask

  function automatic logic signed [15:0] pick_sample(spread_t spread,
                                                     logic signed [15:0] base);
    case (spread)
      SPREAD_FULL:   return 16'($urandom);
      SPREAD_NARROW: return base + 16'($urandom_range(0, 40)) - 16'sd20;
      SPREAD_RAIL:   return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default:       return base;
    endcase
  endfunction

  // start = 0 gives stray samples; the tag fields then carry random noise
  task automatic send_wave(bit start, logic [4:0] brd, logic [4:0] ch, bit ob, bit rn,
                           int nsamp, spread_t spread);
    in_item_t           it;
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < nsamp; i++) begin
      it                   = IN_W'($urandom);
      it.sample            = pick_sample(spread, base);
      it.start_of_waveform = start && (i == 0);
      if (it.start_of_waveform) begin
        it.board           = brd;
        it.channel         = ch;
        it.trigger_offbeam = ob;
        it.trigger_random  = rn;
      end
      send_sample(it);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sdev.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every expected result is out and the sequencer has settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sdev.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [4:0] enabled_board();
    logic [4:0] b;
    b = 5'($urandom);
    for (int i = 0; i < 16 && !sdev.board_mask[b]; i++) b = 5'($urandom);
    return b;
  endfunction

  task automatic random_traffic(int quota);
    int      target, pick, len, flags;
    spread_t spread;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick   = $urandom_range(0, 99);
      len    = sdev.eff_len();
      spread = spread_t'($urandom_range(0, 3));
      flags  = $urandom_range(1, 3);
      if (pick < 70) begin
        send_wave(1'b1, enabled_board(), 5'($urandom), flags[0], flags[1], len, spread);
        // trailing samples past the window end are ignored
        if ($urandom_range(0, 99) < 15)
          send_wave(1'b0, '0, '0, 1'b0, 1'b0, $urandom_range(1, 5), spread);
      end else if (pick < 80) begin
        // cut short: the next start drops it
        send_wave(1'b1, enabled_board(), 5'($urandom), flags[0], flags[1],
                  $urandom_range(1, len - 1), spread);
      end else if (pick < 90) begin
        if ($urandom_range(0, 1))
          send_wave(1'b1, 5'($urandom), 5'($urandom), 1'b0, 1'b0, $urandom_range(1, 6),
                    spread);
        else
          send_wave(1'b1, 5'($urandom), 5'($urandom), flags[0], flags[1],
                    $urandom_range(1, 6), spread);
      end else begin
        send_wave(1'b0, '0, '0, 1'b0, 1'b0, $urandom_range(1, 4), spread);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: board 0 disabled, window of four
    write_reg(CFG_BOARD_ENABLE, 32'hFFFF_FFFE);
    write_reg(CFG_WINDOW_LENGTH, 32'd4);
    send_wave(1'b0, 5'd31, 5'd31, 1'b1, 1'b1, 2, SPREAD_RAIL);
    send_wave(1'b1, 5'd31, 5'd31, 1'b1, 1'b0, 4, SPREAD_RAIL);
    send_wave(1'b1, 5'd0, 5'd0, 1'b0, 1'b1, 2, SPREAD_FULL);
    send_wave(1'b1, 5'd5, 5'd0, 1'b0, 1'b0, 1, SPREAD_FULL);
    send_wave(1'b1, 5'd1, 5'd7, 1'b1, 1'b1, 4, SPREAD_FLAT);
    send_wave(1'b1, 5'd2, 5'd9, 1'b0, 1'b1, 2, SPREAD_NARROW);
    send_wave(1'b1, 5'd3, 5'd17, 1'b0, 1'b1, 4, SPREAD_FULL);
    send_wave(1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 2, SPREAD_FULL);
    drain();

    // length below the minimum acts as two
    write_reg(CFG_WINDOW_LENGTH, 32'd0);
    send_wave(1'b1, 5'd16, 5'd31, 1'b1, 1'b0, 2, SPREAD_FULL);
    drain();

    // shrink the window mid-waveform: the next sample closes it
    write_reg(CFG_WINDOW_LENGTH, 32'd10);
    send_wave(1'b1, 5'd2, 5'd3, 1'b1, 1'b0, 5, SPREAD_NARROW);
    drain();
    write_reg(CFG_WINDOW_LENGTH, 32'd3);
    send_wave(1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1, SPREAD_NARROW);
    drain();

    // longest window, length above the maximum with junk in the upper bits
    write_reg(CFG_BOARD_ENABLE, 32'hFFFF_FFFF);
    write_reg(CFG_WINDOW_LENGTH, 32'hA5A5_FFFF);
    send_wave(1'b1, 5'd20, 5'd11, 1'b1, 1'b1, 1024, SPREAD_FULL);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_BOARD_ENABLE, 32'hFFFF_FFFF);
          write_reg(CFG_WINDOW_LENGTH, 32'd1);
        end
        1: begin
          write_reg(CFG_BOARD_ENABLE, $urandom);
          write_reg(CFG_WINDOW_LENGTH, $urandom_range(3, 12));
        end
        2: begin
          write_reg(CFG_BOARD_ENABLE, 32'h0000_0000);
          write_reg(CFG_WINDOW_LENGTH, 32'd5);
        end
        3: begin
          steady = 1'b1;
          write_reg(CFG_BOARD_ENABLE, $urandom | $urandom);
          write_reg(CFG_WINDOW_LENGTH, $urandom_range(2, 24));
        end
        4: begin
          write_reg(CFG_BOARD_ENABLE, 32'h8000_0001);
          write_reg(CFG_WINDOW_LENGTH, 32'd2);
        end
        default: begin
          write_reg(CFG_BOARD_ENABLE, 32'hFFFF_FFFF);
          write_reg(CFG_WINDOW_LENGTH,
                    {21'($urandom_range(0, 2 ** 21 - 1)), 11'd0} |
                    32'($urandom_range(2, 40)));
        end
      endcase
      random_traffic(phase == 2 ? 60 : RANDOM_ITEMS / 5);
      drain();
      steady = 1'b0;
    end

    if (sdev.errors == 0 && sdev.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
